// ===== hdl/mte_pkg.sv =====
`default_nettype none
package mte_pkg;

  // Field widths
  localparam int CharW  = 8;
  localparam int TimeW  = 16;
  localparam int StatW  = 2;
  localparam int IdxW   = 6;
  localparam int CountW = 3;
  localparam int BitsW  = 5;
  localparam int CfgIdxW = 8;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_DOT        = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_DASH       = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_ELEM_GAP   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_LETTER_GAP = 8'd3;

  // Register reset values
  localparam logic [TimeW-1:0] DOT_RST        = 16'd100;
  localparam logic [TimeW-1:0] DASH_RST       = 16'd500;
  localparam logic [TimeW-1:0] ELEM_GAP_RST   = 16'd250;
  localparam logic [TimeW-1:0] LETTER_GAP_RST = 16'd750;

  // Result status codes
  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_ABORT = 2'd1;
  localparam logic [StatW-1:0] STAT_SKIP  = 2'd2;

  // Index of the first digit in the code table
  localparam logic [IdxW-1:0] DIGIT_BASE = 6'd26;

  // Segment timing registers
  typedef struct packed {
    logic [TimeW-1:0] dot;
    logic [TimeW-1:0] dash;
    logic [TimeW-1:0] elem_gap;
    logic [TimeW-1:0] letter_gap;
  } timing_t;

  // Decoded character: valid flag, element count, element bits (1 = dot)
  typedef struct packed {
    logic              valid;
    logic [CountW-1:0] count;
    logic [BitsW-1:0]  bits;
  } code_t;

  // Morse table: count in the high byte, dot bits LSB first in the low byte
  function automatic logic [15:0] code_rom(input logic [IdxW-1:0] idx);
    logic [15:0] v;
    case (idx)
      6'd0:  v = 16'h0201;
      6'd1:  v = 16'h040E;
      6'd2:  v = 16'h040A;
      6'd3:  v = 16'h0306;
      6'd4:  v = 16'h0101;
      6'd5:  v = 16'h040B;
      6'd6:  v = 16'h0304;
      6'd7:  v = 16'h040F;
      6'd8:  v = 16'h0203;
      6'd9:  v = 16'h0401;
      6'd10: v = 16'h0302;
      6'd11: v = 16'h040D;
      6'd12: v = 16'h0200;
      6'd13: v = 16'h0202;
      6'd14: v = 16'h0300;
      6'd15: v = 16'h0409;
      6'd16: v = 16'h0404;
      6'd17: v = 16'h0305;
      6'd18: v = 16'h0307;
      6'd19: v = 16'h0100;
      6'd20: v = 16'h0303;
      6'd21: v = 16'h0407;
      6'd22: v = 16'h0301;
      6'd23: v = 16'h0406;
      6'd24: v = 16'h0402;
      6'd25: v = 16'h040C;
      6'd26: v = 16'h0500;
      6'd27: v = 16'h0501;
      6'd28: v = 16'h0503;
      6'd29: v = 16'h0507;
      6'd30: v = 16'h050F;
      6'd31: v = 16'h051F;
      6'd32: v = 16'h051E;
      6'd33: v = 16'h051C;
      6'd34: v = 16'h0518;
      6'd35: v = 16'h0510;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/morse_timing_encoder.sv =====
`default_nettype none
// Channel  | Ports                          | Contents
// ---------+--------------------------------+--------------------------------------
// in       | in_tvalid/tready/tdata/tuser   | tdata[7:0] char_code, tuser[0] first
// out      | out_tvalid/tready/tdata/tuser/ | tdata[0] led_on, tdata[16:1] duration,
//          | tlast                          | tuser[1:0] status, tlast last
// cfg      | cfg_valid/ready/index/wdata    | index 0..3 selects a timing register
//
// A character with k segments (1 to 10) is accepted in the idle state; the sequencer
// then emits them one by one and takes no new character until it has emitted the last.
// The sequencer drives a single output register; an output stall holds it in place.
// Reset (rst_n low, synchronous) loads the default timings and clears the abort flag.
// Configuration writes are always taken; index values above 3 are ignored.
module morse_timing_encoder
  import mte_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] char_code
  input  wire logic [0:0]         in_tuser,   // [0] first_of_string
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [23:0]             out_tdata,  // [0] led_on, [16:1] duration, [23:17] zero
  output logic [1:0]              out_tuser,  // [1:0] status
  output logic                    out_tlast,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [TimeW-1:0]   cfg_wdata
);

  timing_t          timing_r, timing_nxt;
  code_t            code;
  logic             seg_led;
  logic [TimeW-1:0] seg_dur;

  assign cfg_ready = 1'b1;

  // Write timing registers
  always_comb begin
    timing_nxt = timing_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_DOT:        timing_nxt.dot        = cfg_wdata;
        REG_DASH:       timing_nxt.dash       = cfg_wdata;
        REG_ELEM_GAP:   timing_nxt.elem_gap   = cfg_wdata;
        REG_LETTER_GAP: timing_nxt.letter_gap = cfg_wdata;
        default:        timing_nxt = timing_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.dot        <= DOT_RST;
      timing_r.dash       <= DASH_RST;
      timing_r.elem_gap   <= ELEM_GAP_RST;
      timing_r.letter_gap <= LETTER_GAP_RST;
    end else begin
      timing_r <= timing_nxt;
    end
  end

  mte_decode u_decode (
    .char_code (in_tdata),
    .code      (code)
  );

  mte_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .timing     (timing_r),
    .code       (code),
    .in_valid   (in_tvalid),
    .in_first   (in_tuser[0]),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_led    (seg_led),
    .out_dur    (seg_dur),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

  // Pack the segment
  assign out_tdata = {7'd0, seg_dur, seg_led};

endmodule
`default_nettype wire

// ===== hdl/mte_decode.sv =====
`default_nettype none
module mte_decode
  import mte_pkg::*;
(
  input  wire logic [CharW-1:0] char_code,
  output code_t                 code
);

  logic [CharW-1:0] upper;
  logic [IdxW-1:0]  idx;
  logic             is_letter;
  logic             is_digit;
  logic [15:0]      entry;

  // Fold lower case onto upper case
  always_comb begin
    upper = char_code;
    if (char_code inside {[8'h61:8'h7A]}) begin
      upper = char_code - 8'h20;
    end
  end

  // Classify and form the table index
  always_comb begin
    is_letter = upper inside {[8'h41:8'h5A]};
    is_digit  = upper inside {[8'h30:8'h39]};
    idx       = '0;
    if (is_letter) begin
      idx = IdxW'(upper - 8'h41);
    end else if (is_digit) begin
      idx = IdxW'(upper - 8'h30) + DIGIT_BASE;
    end
  end

  // Look up element count and dot bits
  always_comb begin
    entry      = code_rom(idx);
    code.valid = is_letter || is_digit;
    code.count = entry[8 +: CountW];
    code.bits  = entry[BitsW-1:0];
  end

endmodule
`default_nettype wire

// ===== hdl/mte_seq.sv =====
`default_nettype none
module mte_seq
  import mte_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire timing_t          timing,
  input  wire code_t            code,
  input  wire logic             in_valid,
  input  wire logic             in_first,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_led,
  output logic [TimeW-1:0]      out_dur,
  output logic [StatW-1:0]      out_status,
  output logic                  out_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_LGAP = 3'd2;
  localparam logic [2:0] S_MARK = 3'd3;
  localparam logic [2:0] S_EGAP = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [BitsW-1:0]  bits_r, bits_nxt;
  logic [StatW-1:0]  err_r, err_nxt;
  logic              aborted_r, aborted_nxt;
  logic              valid_r, valid_nxt;
  logic              led_r, led_nxt;
  logic [TimeW-1:0]  dur_r, dur_nxt;
  logic [StatW-1:0]  status_r, status_nxt;
  logic              last_r, last_nxt;
  logic              slot_free;
  logic              accept;
  logic              skip;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign slot_free  = !valid_r || out_ready;
  assign skip       = aborted_r && !in_first;

  assign out_valid  = valid_r;
  assign out_led    = led_r;
  assign out_dur    = dur_r;
  assign out_status = status_r;
  assign out_last   = last_r;

  // Sequencer: one segment per cycle into the output register while the output slot is free
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    bits_nxt    = bits_r;
    err_nxt     = err_r;
    aborted_nxt = aborted_r;
    valid_nxt   = valid_r;
    led_nxt     = led_r;
    dur_nxt     = dur_r;
    status_nxt  = status_r;
    last_nxt    = last_r;

    // Drop a result once it has been taken
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          aborted_nxt = skip || !code.valid;
          cnt_nxt     = code.count;
          bits_nxt    = code.bits;
          if (skip) begin
            err_nxt   = STAT_SKIP;
            state_nxt = S_ERR;
          end else if (!code.valid) begin
            err_nxt   = STAT_ABORT;
            state_nxt = S_ERR;
          end else if (in_first) begin
            state_nxt = S_MARK;
          end else begin
            state_nxt = S_LGAP;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          valid_nxt  = 1'b1;
          led_nxt    = 1'b0;
          dur_nxt    = '0;
          status_nxt = err_r;
          last_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_LGAP, S_EGAP: begin
        if (slot_free) begin
          valid_nxt  = 1'b1;
          led_nxt    = 1'b0;
          dur_nxt    = (state_r == S_LGAP) ? timing.letter_gap : timing.elem_gap;
          status_nxt = STAT_OK;
          last_nxt   = 1'b0;
          state_nxt  = S_MARK;
        end
      end
      S_MARK: begin
        if (slot_free) begin
          valid_nxt  = 1'b1;
          led_nxt    = 1'b1;
          dur_nxt    = bits_r[0] ? timing.dot : timing.dash;
          status_nxt = STAT_OK;
          last_nxt   = (cnt_r == CountW'(1));
          bits_nxt   = bits_r >> 1;
          cnt_nxt    = cnt_r - CountW'(1);
          state_nxt  = (cnt_r == CountW'(1)) ? S_IDLE : S_EGAP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      aborted_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      aborted_r <= aborted_nxt;
      valid_r   <= valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    bits_r   <= bits_nxt;
    err_r    <= err_nxt;
    led_r    <= led_nxt;
    dur_r    <= dur_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("sequencer idle after a transfer in");

  a_mark_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> (cnt_r != '0))
    else $error("element emitted with no elements left");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (status_r != STAT_OK)) |-> (last_r && !led_r && (dur_r == '0)))
    else $error("error result not a single zero segment");

  a_abort_from_error: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(aborted_r) |-> (state_r == S_ERR))
    else $error("abort flag set without an error result");

endmodule
`default_nettype wire

// ===== tb/tb_morse_timing_encoder.sv =====
`default_nettype none
module tb_morse_timing_encoder;
  import mte_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 77;
  localparam int DRILL_ROWS = 24;

  // One LED segment as seen on the result channel
  typedef struct packed {
    logic             led;
    logic [TimeW-1:0] dur;
    logic [StatW-1:0] stat;
    logic             last;
  } seg_t;

  // Directed row: character, first flag, and a typed-in single segment when pinned
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             first;
    logic             pinned;
    seg_t             seg;
  } drill_row_t;

  localparam seg_t NO_SEG = '0;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;   // [7:0] char_code
  logic [0:0]         in_tuser;   // [0] first_of_string
  logic               out_tvalid;
  logic               out_tready;
  logic [23:0]        out_tdata;  // [0] led_on, [16:1] duration, [23:17] zero
  logic [1:0]         out_tuser;  // [1:0] status
  logic               out_tlast;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TimeW-1:0]   cfg_wdata;

  // Predictor state: timing registers and the abort flag
  logic [TimeW-1:0] t_dot;
  logic [TimeW-1:0] t_dash;
  logic [TimeW-1:0] t_elem_gap;
  logic [TimeW-1:0] t_letter_gap;
  logic             str_aborted;

  seg_t       pending_segs [$];
  drill_row_t drill [DRILL_ROWS];
  int         err_cnt;
  int         cycle_cnt;
  logic       rx_calm;

  morse_timing_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Standard Morse patterns: letters A..Z, then digits 0..9
  function automatic string morse_of(input int sym);
    case (sym)
      0: return ".-";      1: return "-...";    2: return "-.-.";    3: return "-..";
      4: return ".";       5: return "..-.";    6: return "--.";     7: return "....";
      8: return "..";      9: return ".---";    10: return "-.-";    11: return ".-..";
      12: return "--";     13: return "-.";     14: return "---";    15: return ".--.";
      16: return "--.-";   17: return ".-.";    18: return "...";    19: return "-";
      20: return "..-";    21: return "...-";   22: return ".--";    23: return "-..-";
      24: return "-.--";   25: return "--..";
      26: return "-----";  27: return ".----";  28: return "..---";  29: return "...--";
      30: return "....-";  31: return ".....";  32: return "-....";  33: return "--...";
      34: return "---..";  35: return "----.";
      default: return "";
    endcase
  endfunction

  function automatic seg_t mk_seg(input logic led, input logic [TimeW-1:0] dur,
                                  input logic [StatW-1:0] stat, input logic last);
    seg_t s;
    s.led  = led;
    s.dur  = dur;
    s.stat = stat;
    s.last = last;
    return s;
  endfunction

  // Work out the segments that key one character and queue them
  task automatic key_char(input logic [CharW-1:0] ch, input logic first);
    int    code;
    int    sym;
    string pat;
    code = int'(ch);
    sym  = -1;
    if (first) str_aborted = 1'b0;
    if (str_aborted) begin
      pending_segs.push_back(mk_seg(1'b0, '0, STAT_SKIP, 1'b1));
    end else begin
      // fold lower case
      if (code >= "a" && code <= "z") code = code - 32;
      if (code >= "A" && code <= "Z") sym = code - "A";
      else if (code >= "0" && code <= "9") sym = code - "0" + 26;
      if (sym < 0) begin
        str_aborted = 1'b1;
        pending_segs.push_back(mk_seg(1'b0, '0, STAT_ABORT, 1'b1));
      end else begin
        pat = morse_of(sym);
        if (!first) pending_segs.push_back(mk_seg(1'b0, t_letter_gap, STAT_OK, 1'b0));
        for (int m = 0; m < pat.len(); m++) begin
          if (m > 0) pending_segs.push_back(mk_seg(1'b0, t_elem_gap, STAT_OK, 1'b0));
          pending_segs.push_back(mk_seg(1'b1, (pat[m] == ".") ? t_dot : t_dash, STAT_OK,
                                        m == pat.len() - 1));
        end
      end
    end
  endtask

  // Present one character and wait for its transfer
  task automatic send_char(input logic [CharW-1:0] ch, input logic first, input logic calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    key_char(ch, first);
  endtask

  // Drop valid and hold until every queued segment has come out
  task automatic settle_out();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; valid stays high for back-to-back writes
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DOT:        t_dot        = val;
      REG_DASH:       t_dash       = val;
      REG_ELEM_GAP:   t_elem_gap   = val;
      REG_LETTER_GAP: t_letter_gap = val;
      default: ;
    endcase
  endtask

  task automatic program_timing(input logic [TimeW-1:0] dot, input logic [TimeW-1:0] dash,
                                input logic [TimeW-1:0] egap, input logic [TimeW-1:0] lgap);
    settle_out();
    write_reg(REG_DOT, dot);
    write_reg(REG_DASH, dash);
    write_reg(REG_ELEM_GAP, egap);
    write_reg(REG_LETTER_GAP, lgap);
    // out-of-range index must leave the timings alone
    write_reg(CfgIdxW'($urandom_range(4, 255)), TimeW'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cmp(input string what, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Check each result transfer against the oldest queued segment
  always @(posedge clk) begin
    seg_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_segs.size() == 0) begin
        $display("%0t: unexpected segment, expected none, actual led %0h dur %0h st %0h last %0h",
                 $time, out_tdata[0], out_tdata[16:1], out_tuser, out_tlast);
        err_cnt++;
      end else begin
        want = pending_segs.pop_front();
        cmp("led_on", want.led, out_tdata[0]);
        cmp("duration", want.dur, out_tdata[16:1]);
        cmp("status", want.stat, out_tuser);
        cmp("last", want.last, out_tlast);
        cmp("tdata pad", 0, out_tdata[23:17]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls per segment, with calm stretches
  initial begin
    int stall;
    out_tready <= 1'b0;
    rx_calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_calm = ~rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Directed table: expected segment typed in where it is obvious
  initial begin
    drill[0]  = {"E",   1'b1, 1'b1, 1'b1, DOT_RST,  STAT_OK,    1'b1};
    drill[1]  = {"T",   1'b1, 1'b1, 1'b1, DASH_RST, STAT_OK,    1'b1};
    drill[2]  = {"e",   1'b0, 1'b0, NO_SEG};
    drill[3]  = {"a",   1'b0, 1'b0, NO_SEG};
    drill[4]  = {"Z",   1'b0, 1'b0, NO_SEG};
    drill[5]  = {"0",   1'b0, 1'b0, NO_SEG};
    drill[6]  = {"9",   1'b0, 1'b0, NO_SEG};
    drill[7]  = {"R",   1'b0, 1'b0, NO_SEG};
    drill[8]  = {"U",   1'b0, 1'b0, NO_SEG};
    drill[9]  = {8'h00, 1'b0, 1'b1, 1'b0, 16'd0,    STAT_ABORT, 1'b1};
    drill[10] = {"A",   1'b0, 1'b1, 1'b0, 16'd0,    STAT_SKIP,  1'b1};
    drill[11] = {8'hFF, 1'b0, 1'b1, 1'b0, 16'd0,    STAT_SKIP,  1'b1};
    drill[12] = {"z",   1'b1, 1'b0, NO_SEG};
    drill[13] = {8'hFF, 1'b0, 1'b1, 1'b0, 16'd0,    STAT_ABORT, 1'b1};
    drill[14] = {"@",   1'b1, 1'b1, 1'b0, 16'd0,    STAT_ABORT, 1'b1};
    drill[15] = {"[",   1'b1, 1'b1, 1'b0, 16'd0,    STAT_ABORT, 1'b1};
    drill[16] = {8'h60, 1'b1, 1'b1, 1'b0, 16'd0,    STAT_ABORT, 1'b1};
    drill[17] = {"{",   1'b1, 1'b1, 1'b0, 16'd0,    STAT_ABORT, 1'b1};
    drill[18] = {"/",   1'b1, 1'b1, 1'b0, 16'd0,    STAT_ABORT, 1'b1};
    drill[19] = {":",   1'b1, 1'b1, 1'b0, 16'd0,    STAT_ABORT, 1'b1};
    drill[20] = {8'h80, 1'b1, 1'b1, 1'b0, 16'd0,    STAT_ABORT, 1'b1};
    drill[21] = {"5",   1'b1, 1'b0, NO_SEG};
    drill[22] = {"y",   1'b0, 1'b0, NO_SEG};
    drill[23] = {"M",   1'b0, 1'b0, NO_SEG};
  end

  // Main sequence
  initial begin
    int               sent;
    int               str_len;
    int               pick;
    logic             first;
    logic             calm;
    logic [CharW-1:0] ch;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    t_dot        = DOT_RST;
    t_dash       = DASH_RST;
    t_elem_gap   = ELEM_GAP_RST;
    t_letter_gap = LETTER_GAP_RST;
    str_aborted  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows on reset timings
    for (int r = 0; r < DRILL_ROWS; r++) begin
      send_char(drill[r].ch, drill[r].first, ($urandom_range(0, 1) == 1));
      // every pinned row keys a single segment: swap in the typed one
      if (drill[r].pinned) begin
        void'(pending_segs.pop_back());
        pending_segs.push_back(drill[r].seg);
      end
    end

    // Random strings under several timing settings
    for (int p = 1; p <= 5; p++) begin
      case (p)
        1: program_timing(TimeW'($urandom_range(1, 2000)), TimeW'($urandom_range(1, 2000)),
                          TimeW'($urandom_range(1, 2000)), TimeW'($urandom_range(1, 2000)));
        2: program_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        3: program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        4: program_timing(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        default: program_timing(TimeW'($urandom_range(0, 65535)),
                                TimeW'($urandom_range(0, 65535)),
                                TimeW'($urandom_range(0, 65535)),
                                TimeW'($urandom_range(0, 65535)));
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        str_len = $urandom_range(1, 8);
        calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < str_len; k++) begin
          first = (k == 0);
          // break the string framing now and then
          if ($urandom_range(0, 19) == 0) first = ~first;
          if ($urandom_range(0, 7) == 0) begin
            ch = CharW'($urandom_range(0, 255));
          end else begin
            pick = $urandom_range(0, 61);
            if (pick < 26) ch = CharW'("A" + pick);
            else if (pick < 52) ch = CharW'("a" + pick - 26);
            else ch = CharW'("0" + pick - 52);
          end
          // hold the sender until the block has drained
          if ($urandom_range(0, 49) == 0) settle_out();
          send_char(ch, first, calm);
          sent++;
        end
      end
    end

    settle_out();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
